[hdl/lsrd_pkg.sv]
// shared types and constants of the lr shift-reduce parse engine
package lsrd_pkg;

    localparam int CHAIN_LIMIT = 63;

    typedef enum logic [1:0] {
        F_LOAD_ACTION = 2'd0,
        F_LOAD_PROD   = 2'd1,
        F_START       = 2'd2,
        F_TOKEN       = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        K_ACK    = 3'd0,
        K_SHIFT  = 3'd1,
        K_REDUCE = 3'd2,
        K_ACCEPT = 3'd3,
        K_ERROR  = 3'd4,
        K_IDLE   = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_ACT,
        S_ACT,
        S_PROD,
        S_POP,
        S_GOTO_BEGIN,
        S_SCAN_GOTO,
        S_GOTO_CHK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        state_index;
        logic [3:0]        entry_slot;
        logic              entry_valid;
        logic [6:0]        symbol;
        logic signed [8:0] action_value;
        logic [5:0]        production_index;
        logic [3:0]        body_length;
        logic              empty_body;
    } item_t;

    typedef struct packed {
        logic  clear_step;
        logic  ld_action;
        logic  ld_prod;
        logic  start;
        logic  tok_latch;
        logic  scan_begin;
        logic  scan_goto;
        logic  scan_step;
        logic  prod_read;
        logic  prod_latch;
        logic  stack_read;
        logic  do_shift;
        logic  do_reduce;
        logic  end_parse;
        logic  emit;
        kind_t kind;
        logic  last;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic active;
        logic sp_zero;
        logic scan_hit;
        logic scan_miss;
        logic act_zero;
        logic act_neg;
        logic shift_bad;
        logic reduce_bad;
        logic pop_bad;
        logic goto_bad;
        logic out_free;
    } sts_t;

endpackage

[hdl/lsrd_in_if.sv]
// input word channel of the parse engine
interface lsrd_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [7:0]        state_index;
    logic [3:0]        entry_slot;
    logic              entry_valid;
    logic [6:0]        symbol;
    logic signed [8:0] action_value;
    logic [5:0]        production_index;
    logic [3:0]        body_length;
    logic              empty_body;

    modport source (
        output valid, func, state_index, entry_slot, entry_valid, symbol,
               action_value, production_index, body_length, empty_body,
        input  ready
    );
    modport sink (
        input  valid, func, state_index, entry_slot, entry_valid, symbol,
               action_value, production_index, body_length, empty_body,
        output ready
    );
endinterface

[hdl/lsrd_out_if.sv]
// result word channel of the parse engine
interface lsrd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] top_state;
    logic [6:0] depth;
    logic       last;

    modport source (
        output valid, kind, value, top_state, depth, last,
        input  ready
    );
    modport sink (
        input  valid, kind, value, top_state, depth, last,
        output ready
    );
endinterface

[hdl/lsrd_ram.sv]
// generic simple dual-port ram with registered read
module lsrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/lsrd_ctrl.sv]
// parse engine sequencer
module lsrd_ctrl import lsrd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] func,
    input  sts_t       sts,
    output logic       in_ready,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= K_ACK;
            last_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.kind   = kind_reg;
        cmd.last   = last_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next  = 1'b1;
                    kind_next  = K_ACK;
                    state_next = S_EMIT;
                    case (func)
                        F_LOAD_ACTION: cmd.ld_action = 1'b1;
                        F_LOAD_PROD:   cmd.ld_prod = 1'b1;
                        F_START:       cmd.start = 1'b1;
                        F_TOKEN:
                        begin
                            if (!sts.active)
                            begin
                                kind_next = K_IDLE;
                            end
                            else if (sts.sp_zero)
                            begin
                                cmd.end_parse = 1'b1;
                                kind_next     = K_ERROR;
                            end
                            else
                            begin
                                cmd.tok_latch  = 1'b1;
                                cmd.scan_begin = 1'b1;
                                state_next     = S_SCAN_ACT;
                            end
                        end
                        default: kind_next = K_ACK;
                    endcase
                end
            end
            S_SCAN_ACT, S_SCAN_GOTO:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit)
                begin
                    state_next = (state_reg == S_SCAN_ACT) ? S_ACT : S_GOTO_CHK;
                end
                else if (sts.scan_miss)
                begin
                    cmd.end_parse = 1'b1;
                    kind_next     = K_ERROR;
                    last_next     = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_ACT:
            begin
                last_next  = 1'b1;
                state_next = S_EMIT;
                if (sts.act_zero)
                begin
                    cmd.end_parse = 1'b1;
                    kind_next     = K_ACCEPT;
                end
                else if (!sts.act_neg)
                begin
                    if (sts.shift_bad)
                    begin
                        cmd.end_parse = 1'b1;
                        kind_next     = K_ERROR;
                    end
                    else
                    begin
                        cmd.do_shift = 1'b1;
                        kind_next    = K_SHIFT;
                    end
                end
                else if (sts.reduce_bad)
                begin
                    cmd.end_parse = 1'b1;
                    kind_next     = K_ERROR;
                end
                else
                begin
                    cmd.prod_read = 1'b1;
                    state_next    = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.prod_latch = 1'b1;
                state_next     = S_POP;
            end
            S_POP:
            begin
                if (sts.pop_bad)
                begin
                    cmd.end_parse = 1'b1;
                    kind_next     = K_ERROR;
                    last_next     = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.stack_read = 1'b1;
                    state_next     = S_GOTO_BEGIN;
                end
            end
            S_GOTO_BEGIN:
            begin
                cmd.scan_begin = 1'b1;
                cmd.scan_goto  = 1'b1;
                state_next     = S_SCAN_GOTO;
            end
            S_GOTO_CHK:
            begin
                state_next = S_EMIT;
                if (sts.goto_bad)
                begin
                    cmd.end_parse = 1'b1;
                    kind_next     = K_ERROR;
                    last_next     = 1'b1;
                end
                else
                begin
                    cmd.do_reduce = 1'b1;
                    kind_next     = K_REDUCE;
                    last_next     = 1'b0;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_begin = 1'b1;
                        state_next     = S_SCAN_ACT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

[hdl/lsrd_dp.sv]
// parse engine datapath: tables, state stack, scan unit and result register
module lsrd_dp import lsrd_pkg::*; #(
    parameter int NUM_STATES        = 256,
    parameter int ENTRIES_PER_STATE = 16,
    parameter int NUM_PRODUCTIONS   = 64,
    parameter int STACK_DEPTH       = 64,
    parameter int MAX_BODY          = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [2:0] out_kind,
    output logic [7:0] out_value,
    output logic [7:0] out_top,
    output logic [6:0] out_depth,
    output logic       out_last
);
    localparam int TOTAL = NUM_STATES * ENTRIES_PER_STATE;
    localparam int AW    = $clog2(TOTAL);
    localparam int SW    = $clog2(NUM_STATES);
    localparam int KW    = $clog2(STACK_DEPTH);
    localparam int PTW   = $clog2(STACK_DEPTH + 1);
    localparam int PW    = $clog2(NUM_PRODUCTIONS);
    localparam int CW    = $clog2(ENTRIES_PER_STATE + 1);

    logic [AW-1:0]     clr_reg, clr_next;
    logic              active_reg, active_next;
    logic [PTW-1:0]    sp_reg, sp_next;
    logic [SW-1:0]     top_reg, top_next;
    logic [5:0]        reds_reg, reds_next;
    logic [CW-1:0]     slot_reg, slot_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [6:0]        tok_reg, tok_next;
    logic [SW-1:0]     scan_st_reg, scan_st_next;
    logic [6:0]        scan_sym_reg, scan_sym_next;
    logic signed [8:0] act_reg, act_next;
    logic [8:0]        p_reg, p_next;
    logic [6:0]        lhs_reg, lhs_next;
    logic [3:0]        pops_reg, pops_next;
    logic [PTW-1:0]    newsp_reg, newsp_next;
    logic [2:0]        kind_reg, kind_next;
    logic [7:0]        value_reg, value_next;
    logic [7:0]        otop_reg, otop_next;
    logic [6:0]        odepth_reg, odepth_next;
    logic              olast_reg, olast_next;

    logic          act_we;
    logic [AW-1:0] act_waddr, act_raddr;
    logic [16:0]   act_wdata, act_rdata;
    logic          prod_we;
    logic [PW-1:0] prod_waddr, prod_raddr;
    logic [11:0]   prod_wdata, prod_rdata;
    logic          stk_we;
    logic [KW-1:0] stk_waddr, stk_raddr;
    logic [SW-1:0] stk_wdata, stk_rdata;

    logic           ld_ok;
    logic [3:0]     body_clamp;
    logic [8:0]     p_now;
    logic [3:0]     prod_body;
    logic [PTW-1:0] rd_sp;

    assign ld_ok = (32'(item.state_index) < NUM_STATES)
                && (32'(item.entry_slot) < ENTRIES_PER_STATE);
    assign body_clamp = (32'(item.body_length) > MAX_BODY) ? 4'(MAX_BODY) : item.body_length;
    assign p_now      = 9'(-act_reg);
    assign prod_body  = prod_rdata[4:1];
    assign rd_sp      = sp_reg - PTW'(pops_reg) - PTW'(1);

    assign act_we    = cmd.clear_step | (cmd.ld_action & ld_ok);
    assign act_waddr = cmd.clear_step ? clr_reg
        : AW'(32'(item.state_index) * ENTRIES_PER_STATE + 32'(item.entry_slot));
    assign act_wdata = cmd.clear_step ? 17'd0
        : {item.entry_valid, item.symbol, item.action_value};
    assign act_raddr = AW'(32'(scan_st_reg) * ENTRIES_PER_STATE + 32'(slot_reg));

    assign prod_we    = cmd.ld_prod && (32'(item.production_index) < NUM_PRODUCTIONS);
    assign prod_waddr = PW'(item.production_index);
    assign prod_wdata = {item.symbol, body_clamp, item.empty_body};
    assign prod_raddr = PW'(p_now);

    assign stk_we    = cmd.start | cmd.do_shift | cmd.do_reduce;
    assign stk_waddr = cmd.start ? KW'(0) : (cmd.do_shift ? sp_reg[KW-1:0] : newsp_reg[KW-1:0]);
    assign stk_wdata = cmd.start ? SW'(0) : SW'(act_reg[7:0]);
    assign stk_raddr = rd_sp[KW-1:0];

    lsrd_ram #(.WIDTH(17), .DEPTH(TOTAL)) u_action_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    lsrd_ram #(.WIDTH(12), .DEPTH(NUM_PRODUCTIONS)) u_prod_ram (
        .clk   (clk),
        .we    (prod_we),
        .waddr (prod_waddr),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (prod_rdata)
    );

    lsrd_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        sts.clear_done = (clr_reg == AW'(TOTAL - 1));
        sts.active     = active_reg;
        sts.sp_zero    = (sp_reg == '0);
        sts.scan_hit   = pend_reg && act_rdata[16] && (act_rdata[15:9] == scan_sym_reg);
        sts.scan_miss  = !pend_reg && (slot_reg == CW'(ENTRIES_PER_STATE));
        sts.act_zero   = (act_reg == 9'sd0);
        sts.act_neg    = act_reg[8];
        sts.shift_bad  = (32'(act_reg[7:0]) >= NUM_STATES) || (32'(sp_reg) >= STACK_DEPTH);
        sts.reduce_bad = (reds_reg >= 6'(CHAIN_LIMIT)) || (32'(p_now) >= NUM_PRODUCTIONS);
        sts.pop_bad    = (32'(pops_reg) >= 32'(sp_reg));
        sts.goto_bad   = act_reg[8] || (act_reg == 9'sd0)
                      || (32'(act_reg[7:0]) >= NUM_STATES)
                      || (32'(newsp_reg) >= STACK_DEPTH);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        clr_next       = cmd.clear_step ? clr_reg + AW'(1) : clr_reg;
        active_next    = active_reg;
        sp_next        = sp_reg;
        top_next       = top_reg;
        reds_next      = reds_reg;
        slot_next      = slot_reg;
        pend_next      = pend_reg;
        tok_next       = cmd.tok_latch ? item.symbol : tok_reg;
        scan_st_next   = scan_st_reg;
        scan_sym_next  = scan_sym_reg;
        act_next       = act_reg;
        p_next         = cmd.prod_read ? p_now : p_reg;
        lhs_next       = cmd.prod_latch ? prod_rdata[11:5] : lhs_reg;
        pops_next      = pops_reg;
        newsp_next     = cmd.stack_read ? sp_reg - PTW'(pops_reg) : newsp_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        otop_next      = otop_reg;
        odepth_next    = odepth_reg;
        olast_next     = olast_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (cmd.prod_latch)
        begin
            pops_next = prod_body - 4'(prod_rdata[0] && (prod_body != 4'd0));
        end
        if (cmd.start)
        begin
            sp_next     = PTW'(1);
            top_next    = '0;
            active_next = 1'b1;
        end
        if (cmd.end_parse)
        begin
            active_next = 1'b0;
        end
        if (cmd.tok_latch)
        begin
            reds_next = '0;
        end
        if (cmd.do_shift)
        begin
            sp_next  = sp_reg + PTW'(1);
            top_next = SW'(act_reg[7:0]);
        end
        if (cmd.do_reduce)
        begin
            sp_next   = newsp_reg + PTW'(1);
            top_next  = SW'(act_reg[7:0]);
            reds_next = reds_reg + 6'd1;
        end
        if (cmd.scan_begin)
        begin
            slot_next     = '0;
            pend_next     = 1'b0;
            scan_st_next  = cmd.scan_goto ? stk_rdata : top_reg;
            scan_sym_next = cmd.scan_goto ? lhs_reg : (cmd.tok_latch ? item.symbol : tok_reg);
        end
        if (cmd.scan_step)
        begin
            if (slot_reg < CW'(ENTRIES_PER_STATE))
            begin
                slot_next = slot_reg + CW'(1);
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (sts.scan_hit)
            begin
                act_next = act_rdata[8:0];
            end
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = cmd.kind;
            otop_next      = 8'(top_reg);
            odepth_next    = 7'(sp_reg);
            olast_next     = cmd.last;
            case (cmd.kind)
                K_SHIFT:  value_next = act_reg[7:0];
                K_REDUCE: value_next = p_reg[7:0];
                default:  value_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            active_reg    <= 1'b0;
            sp_reg        <= '0;
            top_reg       <= '0;
            reds_reg      <= '0;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_reg       <= clr_next;
            active_reg    <= active_next;
            sp_reg        <= sp_next;
            top_reg       <= top_next;
            reds_reg      <= reds_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg      <= tok_next;
        scan_st_reg  <= scan_st_next;
        scan_sym_reg <= scan_sym_next;
        act_reg      <= act_next;
        p_reg        <= p_next;
        lhs_reg      <= lhs_next;
        pops_reg     <= pops_next;
        newsp_reg    <= newsp_next;
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        otop_reg     <= otop_next;
        odepth_reg   <= odepth_next;
        olast_reg    <= olast_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_top   = otop_reg;
    assign out_depth = odepth_reg;
    assign out_last  = olast_reg;
endmodule

[hdl/lr_shift_reduce_driver_core.sv]
// Table-driven LR shift-reduce parse engine, top level.
// After reset the action table in-use bits are cleared by a pass over all
// NUM_STATES*ENTRIES_PER_STATE entries (4096 by default) during which no word
// is accepted. One word is processed at a time. A load, start or ignored
// token is acted on when it is accepted, and its result word is written once
// the result register is free. A token lookup reads the action memory one
// slot per cycle; each chained reduction adds a production read, a stack read
// and a goto lookup. The action memory read port sets the pace.
module lr_shift_reduce_driver_core import lsrd_pkg::*; #(
    parameter int NUM_STATES        = 256,
    parameter int ENTRIES_PER_STATE = 16,
    parameter int NUM_PRODUCTIONS   = 64,
    parameter int STACK_DEPTH       = 64,
    parameter int MAX_BODY          = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    lsrd_in_if.sink     request,
    lsrd_out_if.source  result
);
    item_t item;
    cmd_t  cmd;
    sts_t  sts;

    assign item.func             = request.func;
    assign item.state_index      = request.state_index;
    assign item.entry_slot       = request.entry_slot;
    assign item.entry_valid      = request.entry_valid;
    assign item.symbol           = request.symbol;
    assign item.action_value     = request.action_value;
    assign item.production_index = request.production_index;
    assign item.body_length      = request.body_length;
    assign item.empty_body       = request.empty_body;

    lsrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .func     (request.func),
        .sts      (sts),
        .in_ready (request.ready),
        .cmd      (cmd)
    );

    lsrd_dp #(
        .NUM_STATES        (NUM_STATES),
        .ENTRIES_PER_STATE (ENTRIES_PER_STATE),
        .NUM_PRODUCTIONS   (NUM_PRODUCTIONS),
        .STACK_DEPTH       (STACK_DEPTH),
        .MAX_BODY          (MAX_BODY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_kind  (result.kind),
        .out_value (result.value),
        .out_top   (result.top_state),
        .out_depth (result.depth),
        .out_last  (result.last)
    );

`ifndef SYNTHESIS
    ast_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result word overwritten");

    ast_shift_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == K_SHIFT |-> result.last)
        else $error("shift word not last");

    ast_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.kind == K_ERROR || result.kind == K_ACCEPT) |-> result.last)
        else $error("terminating word not last");

    ast_reduce_chain: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == K_REDUCE |-> !result.last)
        else $error("reduce word marked last");
`endif
endmodule
